### hdl/utf8_text_width_layout_unit_assert.svh
// Assertion macros shared by the layout unit RTL
`ifndef UTF8_TEXT_WIDTH_LAYOUT_UNIT_ASSERT_SVH
`define UTF8_TEXT_WIDTH_LAYOUT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define U8TWL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8twl same-cycle check failed");
// next-cycle implication
`define U8TWL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8twl next-cycle check failed");
`else
`define U8TWL_ASSERT_SAME(label, clk, rst, ante, cons)
`define U8TWL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/u8twl_pkg.sv
// Shared types and constants for the UTF-8 text width layout unit
package u8twl_pkg;

  localparam int CP_W      = 21;
  localparam int GLYPH_W   = 7;
  localparam int PEN_W     = 16;
  localparam int ADV_W     = 9;
  localparam int SCALE_W   = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH    = 2'd2;

  localparam logic [CP_W-1:0] CP_IDEO_SPACE  = 21'h3000;
  localparam logic [CP_W-1:0] CP_FULL_FIRST  = 21'hFF01;
  localparam logic [CP_W-1:0] CP_FULL_LAST   = 21'hFF5E;
  localparam logic [CP_W-1:0] CP_FULL_OFFSET = 21'hFEE0;
  localparam logic [CP_W-1:0] CP_SPACE       = 21'h20;
  localparam logic [CP_W-1:0] CP_QMARK       = 21'd63;
  localparam logic [CP_W-1:0] CP_WIDE_MIN    = 21'h80;
  localparam logic [CP_W-1:0] GLYPH_FIRST    = 21'd32;
  localparam logic [CP_W-1:0] GLYPH_COUNT    = 21'd95;

  localparam logic [GLYPH_W-1:0] GLYPH_QMARK = 7'd31;
  localparam logic [SCALE_W-1:0] SCALE_MAX   = 5'd16;
  localparam logic [PEN_W-1:0]   PEN_MAX     = 16'hFFFF;

  // what follows the substituted '?' characters of one request
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_CHAR,
    TAIL_END
  } tail_t;

  // one decoded input byte, as handed from front to back
  typedef struct packed {
    logic [1:0]         nsub;
    tail_t              tail;
    logic [CP_W-1:0]    code_point;
    logic               wide;
    logic [GLYPH_W-1:0] glyph_index;
    logic               subst;
  } req_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic               limit_enable;
    logic [PEN_W-1:0]   max_width;
  } cfg_t;

endpackage

### hdl/u8twl_front.sv
// Front end: accepts bytes, runs the UTF-8 decoder, builds requests
module u8twl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              q_full,
  output logic              push,
  output u8twl_pkg::req_t   push_req
);
  import u8twl_pkg::*;

  logic [1:0]      cont_needed, cont_needed_next;
  logic [1:0]      cont_seen, cont_seen_next;
  logic [CP_W-1:0] partial_code, partial_code_next;

  logic            accept;
  logic            is_cont;
  logic [1:0]      seen_inc;
  logic [CP_W-1:0] pc_shift;

  tail_t           lp_tail;
  logic [CP_W-1:0] lp_cp;
  logic            lp_subst;
  logic [1:0]      lp_need;
  logic [CP_W-1:0] lp_bits;
  req_t            req;

  // fold, classify and index one character
  function automatic req_t make_char(input logic [CP_W-1:0] cp_raw, input logic subst);
    req_t            r;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] rel;
    cp = cp_raw;
    if (cp_raw == CP_IDEO_SPACE) begin
      cp = CP_SPACE;
    end else if (cp_raw >= CP_FULL_FIRST && cp_raw <= CP_FULL_LAST) begin
      cp = cp_raw - CP_FULL_OFFSET;
    end
    rel           = cp - GLYPH_FIRST;
    r             = '0;
    r.tail        = TAIL_CHAR;
    r.code_point  = cp;
    r.wide        = (cp >= CP_WIDE_MIN);
    r.glyph_index = (cp < CP_WIDE_MIN && cp >= GLYPH_FIRST && rel < GLYPH_COUNT) ?
                    rel[GLYPH_W-1:0] : '0;
    r.subst       = subst;
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign seen_inc = cont_seen + 2'd1;
  assign pc_shift = {partial_code[CP_W-7:0], data_byte[5:0]};

  // lead byte classification
  always_comb begin
    lp_tail  = TAIL_CHAR;
    lp_cp    = {13'd0, data_byte};
    lp_subst = 1'b0;
    lp_need  = 2'd0;
    lp_bits  = '0;
    if (data_byte == 8'd0) begin
      lp_tail = TAIL_END;
    end else if (!data_byte[7]) begin
      lp_tail = TAIL_CHAR;
    end else if (data_byte[7:5] == 3'b110) begin
      lp_tail = TAIL_NONE;
      lp_need = 2'd1;
      lp_bits = {16'd0, data_byte[4:0]};
    end else if (data_byte[7:4] == 4'b1110) begin
      lp_tail = TAIL_NONE;
      lp_need = 2'd2;
      lp_bits = {17'd0, data_byte[3:0]};
    end else if (data_byte[7:3] == 5'b11110) begin
      lp_tail = TAIL_NONE;
      lp_need = 2'd3;
      lp_bits = {18'd0, data_byte[2:0]};
    end else begin
      lp_cp    = CP_QMARK;
      lp_subst = 1'b1;
    end
  end

  always_comb begin
    cont_needed_next  = cont_needed;
    cont_seen_next    = cont_seen;
    partial_code_next = partial_code;
    req               = make_char(lp_cp, lp_subst);
    req.tail          = lp_tail;
    if (cont_needed != 2'd0) begin
      if (is_cont) begin
        req.tail = TAIL_NONE;
        if (seen_inc >= cont_needed) begin
          req               = make_char(pc_shift, 1'b0);
          cont_needed_next  = 2'd0;
          cont_seen_next    = 2'd0;
          partial_code_next = '0;
        end else begin
          cont_seen_next    = seen_inc;
          partial_code_next = pc_shift;
        end
      end else begin
        // broken sequence: '?' for the lead and each held byte, then reparse
        req.nsub          = seen_inc;
        cont_needed_next  = lp_need;
        cont_seen_next    = 2'd0;
        partial_code_next = lp_bits;
      end
    end else begin
      cont_needed_next  = lp_need;
      cont_seen_next    = 2'd0;
      partial_code_next = lp_bits;
    end
  end

  assign push     = accept && (req.nsub != 2'd0 || req.tail != TAIL_NONE);
  assign push_req = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      cont_needed  <= 2'd0;
      cont_seen    <= 2'd0;
      partial_code <= '0;
    end else if (accept) begin
      cont_needed  <= cont_needed_next;
      cont_seen    <= cont_seen_next;
      partial_code <= partial_code_next;
    end
  end

endmodule

### hdl/u8twl_queue.sv
// Request queue between front and back
module u8twl_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8twl_pkg::req_t push_req,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output u8twl_pkg::req_t head
);
  import u8twl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

### hdl/u8twl_back.sv
// Back end: expands requests into results, tracks pen and limit
module u8twl_back (
  input  logic                            clk,
  input  logic                            rst,
  input  u8twl_pkg::cfg_t                 cfg,
  input  logic                            head_valid,
  input  u8twl_pkg::req_t                 head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            kind,
  output logic [u8twl_pkg::CP_W-1:0]      code_point,
  output logic                            wide,
  output logic [u8twl_pkg::GLYPH_W-1:0]   glyph_index,
  output logic [u8twl_pkg::PEN_W-1:0]     x_offset,
  output logic [u8twl_pkg::ADV_W-1:0]     advance,
  output logic                            substituted,
  output logic                            last
);
  import u8twl_pkg::*;

  logic [1:0]       step_idx;
  logic [PEN_W-1:0] pen;
  logic             halted;

  logic [SCALE_W-1:0] sc_eff;
  logic [ADV_W-1:0]   adv_n, adv_w, cur_adv, nxt_adv;
  logic [2:0]         total_steps, nxt_idx;
  logic               step_last, at_q, nxt_q;
  logic               cur_char, cur_end, cur_wide, nxt_is_char;
  logic [PEN_W:0]     sum1;
  logic [PEN_W+1:0]   sum2;
  logic               fits1, fits2, emit, more, go;

  always_comb begin
    if (cfg.scale == '0) begin
      sc_eff = 5'd1;
    end else if (cfg.scale > SCALE_MAX) begin
      sc_eff = SCALE_MAX;
    end else begin
      sc_eff = cfg.scale;
    end
  end

  assign adv_n = {1'b0, sc_eff, 3'b000};
  assign adv_w = {sc_eff, 4'b0000};

  assign total_steps = {1'b0, head.nsub} + {2'b00, head.tail != TAIL_NONE};
  assign step_last   = ({1'b0, step_idx} == total_steps - 3'd1);
  assign nxt_idx     = {1'b0, step_idx} + 3'd1;
  assign at_q        = (step_idx < head.nsub);
  assign nxt_q       = (nxt_idx < {1'b0, head.nsub});

  assign cur_char = at_q || head.tail == TAIL_CHAR;
  assign cur_end  = !at_q && head.tail == TAIL_END;
  assign cur_wide = !at_q && head.wide;
  assign cur_adv  = cur_wide ? adv_w : adv_n;

  // does this character fit, and would the next one fit after it
  assign nxt_is_char = nxt_q || head.tail == TAIL_CHAR;
  assign nxt_adv     = (!nxt_q && head.wide) ? adv_w : adv_n;
  assign sum1        = {1'b0, pen} + {8'd0, cur_adv};
  assign sum2        = {1'b0, sum1} + {9'd0, nxt_adv};
  assign fits1       = !cfg.limit_enable || sum1 <= {1'b0, cfg.max_width};
  assign fits2       = !cfg.limit_enable || sum2 <= {2'b00, cfg.max_width};

  assign emit = cur_end || (cur_char && !halted && fits1);
  // a pending end result is always emitted, so it closes the burst itself
  assign more = !step_last && (head.tail == TAIL_END || !nxt_is_char || fits2);
  assign go   = head_valid && (!out_valid || !out_stall);
  assign pop  = go && step_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step_idx  <= 2'd0;
      pen       <= '0;
      halted    <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= go && emit;
      end
      if (go) begin
        step_idx <= step_last ? 2'd0 : step_idx + 2'd1;
        if (cur_end) begin
          pen    <= '0;
          halted <= 1'b0;
        end else if (cur_char && !halted) begin
          if (fits1) begin
            pen <= sum1[PEN_W] ? PEN_MAX : sum1[PEN_W-1:0];
          end else begin
            halted <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      kind        <= cur_end;
      code_point  <= cur_end ? '0 : (at_q ? CP_QMARK : head.code_point);
      wide        <= cur_wide;
      glyph_index <= cur_end ? '0 : (at_q ? GLYPH_QMARK : head.glyph_index);
      x_offset    <= pen;
      advance     <= cur_end ? '0 : cur_adv;
      substituted <= !cur_end && (at_q || head.subst);
      last        <= cur_end || !more;
    end
  end

endmodule

### hdl/utf8_text_width_layout_unit.sv
// Top level of the UTF-8 text width layout unit
//
// Input channel: one UTF-8 byte per request on data_byte, taken when
//   in_valid is high and in_stall is low; byte 0 ends the string.
// Output channel: character and end-of-string results on their own
//   ports, taken when out_valid is high and out_stall is low. One input
//   byte gives zero to four results; the final one carries last.
// Configuration: cfg_write with cfg_index/cfg_data writes scale (0),
//   limit_enable (1) or max_width (2); write only while the unit is idle.
// Path: a byte is decoded combinationally, written into the request
//   queue and expanded by the back end into its registered output.
// Throughput: one byte per cycle while each byte yields at most one
//   result and out_stall is low; the back end emits one result per cycle
//   while not stalled, so a malformed sequence that yields several results
//   holds it longer and the request queue (QUEUE_DEPTH entries) absorbs the front.
// Reset: synchronous, clears the decoder, pen position, limit state and
//   queue; registers return to scale 1, limit off, max_width 0.
// A stalled receiver holds the output register; the front keeps taking
//   bytes until the queue fills, then raises in_stall.
module utf8_text_width_layout_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [u8twl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [u8twl_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            kind,
  output logic [u8twl_pkg::CP_W-1:0]      code_point,
  output logic                            wide,
  output logic [u8twl_pkg::GLYPH_W-1:0]   glyph_index,
  output logic [u8twl_pkg::PEN_W-1:0]     x_offset,
  output logic [u8twl_pkg::ADV_W-1:0]     advance,
  output logic                            substituted,
  output logic                            last
);
  import u8twl_pkg::*;

  `include "utf8_text_width_layout_unit_assert.svh"

  cfg_t cfg;
  logic q_push, q_full, q_pop, q_head_valid;
  req_t q_push_req, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale        <= 5'd1;
      cfg.limit_enable <= 1'b0;
      cfg.max_width    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCALE:        cfg.scale        <= cfg_data[SCALE_W-1:0];
        REG_LIMIT_ENABLE: cfg.limit_enable <= cfg_data[0];
        REG_MAX_WIDTH:    cfg.max_width    <= cfg_data[PEN_W-1:0];
        default:          ;
      endcase
    end
  end

  // byte intake and UTF-8 decode
  u8twl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (q_push),
    .push_req  (q_push_req)
  );

  // decouples decode from result delivery
  u8twl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_req   (q_push_req),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // layout, limit and output register
  u8twl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .code_point  (code_point),
    .wide        (wide),
    .glyph_index (glyph_index),
    .x_offset    (x_offset),
    .advance     (advance),
    .substituted (substituted),
    .last        (last)
  );

  // front never pushes into a full queue
  `U8TWL_ASSERT_SAME(a_no_overflow, clk, rst, q_push, !q_full)
  // a full queue stays full until the back end drains an entry
  `U8TWL_ASSERT_NEXT(a_full_holds, clk, rst, q_full && !q_pop, q_full)
  // end-of-string result always closes its byte's burst
  `U8TWL_ASSERT_SAME(a_end_last, clk, rst, out_valid && kind, last && advance == '0)
  // substituted characters always show the replacement mark
  `U8TWL_ASSERT_SAME(a_subst_qmark, clk, rst, out_valid && substituted,
                     code_point == CP_QMARK && !kind)

endmodule
